/* rtl/core/signed_time_value_alu_top_macros.svh */
// assertion macros for the signed time value alu
// expects clk and rst_n in the scope that uses them
`ifndef SIGNED_TIME_VALUE_ALU_TOP_MACROS_SVH
`define SIGNED_TIME_VALUE_ALU_TOP_MACROS_SVH

// same-cycle implication
`define STVA_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define STVA_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/core/stva_pkg.sv */
// shared types and constants for the signed time value alu
// no dependencies
package stva_pkg;

    localparam int SEC_BITS_DEF = 32;
    localparam int IN_BITS      = 32;
    localparam int OP_BITS      = 33;
    localparam int CMD_BITS     = 3;
    localparam int SIGN_BITS    = 2;
    localparam int USEC_BITS    = 21;
    localparam int Q_BITS       = 23;
    localparam int R_BITS       = 20;
    localparam int RECIP_SHIFT  = 32;
    localparam int PIPE_DEPTH   = 6;

    localparam logic [Q_BITS-1:0] RECIP_US = 23'd4295;
    localparam logic [Q_BITS-1:0] RECIP_MS = 23'd4294968;
    localparam logic [R_BITS-1:0] USEC_PER_SEC = 20'd1000000;
    localparam logic [R_BITS-1:0] USEC_PER_MS  = 20'd1000;

    typedef enum logic [CMD_BITS-1:0] {
        CMD_ADD    = 3'd0,
        CMD_SUB    = 3'd1,
        CMD_ADD_MS = 3'd2,
        CMD_CMP    = 3'd3,
        CMD_NORM   = 3'd4
    } cmd_t;

    typedef enum logic [SIGN_BITS-1:0] {
        SIGN_NEG  = 2'd0,
        SIGN_ZERO = 2'd1,
        SIGN_POS  = 2'd2
    } sign_t;

    typedef struct packed {
        logic add_b;
        logic is_cmp;
    } ctl_t;

endpackage

/* rtl/core/stva_norm.sv */
// three-stage operand normalizer: reciprocal divide of microseconds (or milliseconds),
// remainder correction, sign fix-up and seconds wrap
// depends on stva_pkg
module stva_norm #(
    parameter int SEC_BITS = stva_pkg::SEC_BITS_DEF
) (
    input  logic                                  clk,
    input  logic                                  en,
    input  logic                                  ms_mode,
    input  logic signed [stva_pkg::OP_BITS-1:0]   op_sec,
    input  logic signed [stva_pkg::OP_BITS-1:0]   op_usec,
    output logic signed [SEC_BITS-1:0]            sec,
    output logic signed [stva_pkg::USEC_BITS-1:0] usec,
    output logic                                  ovf
);

    localparam int OP        = stva_pkg::OP_BITS;
    localparam int QB        = stva_pkg::Q_BITS;
    localparam int RB        = stva_pkg::R_BITS;
    localparam int UB        = stva_pkg::USEC_BITS;
    localparam int MAG_BITS  = OP - 1;
    localparam int PROD_BITS = stva_pkg::RECIP_SHIFT + QB;
    localparam int QD_BITS   = QB + RB;
    localparam int DIFF_BITS = MAG_BITS + 3;
    localparam int SW        = SEC_BITS + 3;
    localparam logic signed [UB-1:0] USEC_S = $signed({1'b0, stva_pkg::USEC_PER_SEC});

    // stage 1: magnitude times reciprocal
    logic                 neg1;
    logic [OP-1:0]        abs1;
    logic [MAG_BITS-1:0]  mag1;
    logic [QB-1:0]        recip1;
    logic [PROD_BITS-1:0] prod1;

    logic signed [OP-1:0] s1_sec_reg;
    logic                 s1_neg_reg;
    logic                 s1_ms_reg;
    logic [MAG_BITS-1:0]  s1_mag_reg;
    logic [QB-1:0]        s1_q_reg;

    assign neg1   = !ms_mode && op_usec[OP-1];
    assign abs1   = neg1 ? -op_usec : op_usec;
    assign mag1   = abs1[MAG_BITS-1:0];
    assign recip1 = ms_mode ? stva_pkg::RECIP_MS : stva_pkg::RECIP_US;
    assign prod1  = PROD_BITS'(mag1) * PROD_BITS'(recip1);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_sec_reg <= op_sec;
            s1_neg_reg <= neg1;
            s1_ms_reg  <= ms_mode;
            s1_mag_reg <= mag1;
            s1_q_reg   <= prod1[stva_pkg::RECIP_SHIFT +: QB];
        end
    end

    // stage 2: remainder and quotient correction
    logic [RB-1:0]               div2;
    logic [QD_BITS-1:0]          qd2;
    logic signed [DIFF_BITS-1:0] diff2;
    logic [QB-1:0]               q2;
    logic [RB-1:0]               r2;

    logic signed [OP-1:0] s2_sec_reg;
    logic                 s2_neg_reg;
    logic                 s2_ms_reg;
    logic [QB-1:0]        s2_q_reg;
    logic [RB-1:0]        s2_r_reg;

    assign div2  = s1_ms_reg ? stva_pkg::USEC_PER_MS : stva_pkg::USEC_PER_SEC;
    assign qd2   = QD_BITS'(s1_q_reg) * QD_BITS'(div2);
    assign diff2 = $signed(DIFF_BITS'(s1_mag_reg)) - $signed(qd2[DIFF_BITS-1:0]);

    always_comb
    begin
        if (diff2[DIFF_BITS-1])
        begin
            q2 = s1_q_reg - QB'(1);
            r2 = diff2[RB-1:0] + div2;
        end
        else
        begin
            q2 = s1_q_reg;
            r2 = diff2[RB-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s2_sec_reg <= s1_sec_reg;
            s2_neg_reg <= s1_neg_reg;
            s2_ms_reg  <= s1_ms_reg;
            s2_q_reg   <= q2;
            s2_r_reg   <= r2;
        end
    end

    // stage 3: signed fold into seconds, sign fix-up, wrap, or ms remainder to usec
    logic signed [QB:0]     qs3;
    logic signed [UB-1:0]   rs3;
    logic signed [SW-1:0]   s3;
    logic signed [SW-1:0]   sf3;
    logic signed [UB-1:0]   uf3;
    logic [SEC_BITS-1:0]    w3;
    logic [2*RB-1:0]        msu3;
    logic signed [SEC_BITS-1:0] sec3;
    logic signed [UB-1:0]   usec3;
    logic                   ovf3;

    logic signed [SEC_BITS-1:0] sec_reg;
    logic signed [UB-1:0]       usec_reg;
    logic                       ovf_reg;

    assign qs3 = s2_neg_reg ? -$signed({1'b0, s2_q_reg}) : $signed({1'b0, s2_q_reg});
    assign rs3 = s2_neg_reg ? -$signed({1'b0, s2_r_reg}) : $signed({1'b0, s2_r_reg});
    assign s3  = SW'(s2_sec_reg) + SW'(qs3);

    always_comb
    begin
        if (s3 > 0 && rs3 < 0)
        begin
            sf3 = s3 - SW'(1);
            uf3 = rs3 + USEC_S;
        end
        else if (s3 < 0 && rs3 > 0)
        begin
            sf3 = s3 + SW'(1);
            uf3 = rs3 - USEC_S;
        end
        else
        begin
            sf3 = s3;
            uf3 = rs3;
        end
    end

    assign w3   = sf3[SEC_BITS-1:0];
    assign msu3 = (2*RB)'(s2_r_reg) * (2*RB)'(stva_pkg::USEC_PER_MS);

    always_comb
    begin
        if (s2_ms_reg)
        begin
            sec3  = $signed({{(SEC_BITS-QB){1'b0}}, s2_q_reg});
            usec3 = $signed({1'b0, msu3[RB-1:0]});
            ovf3  = 1'b0;
        end
        else
        begin
            sec3  = $signed(w3);
            usec3 = uf3;
            ovf3  = (SW'($signed(w3)) != sf3);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sec_reg  <= sec3;
            usec_reg <= usec3;
            ovf_reg  <= ovf3;
        end
    end

    assign sec  = sec_reg;
    assign usec = usec_reg;
    assign ovf  = ovf_reg;

endmodule

/* rtl/core/stva_comb.sv */
// two-stage combiner: operand sum with microsecond carry and compare,
// then sign fix-up, seconds wrap and sign code
// depends on stva_pkg
module stva_comb #(
    parameter int SEC_BITS = stva_pkg::SEC_BITS_DEF
) (
    input  logic                                  clk,
    input  logic                                  en,
    input  stva_pkg::ctl_t                        ctl,
    input  logic signed [SEC_BITS-1:0]            a_sec,
    input  logic signed [stva_pkg::USEC_BITS-1:0] a_usec,
    input  logic                                  a_ovf,
    input  logic signed [SEC_BITS-1:0]            b_sec,
    input  logic signed [stva_pkg::USEC_BITS-1:0] b_usec,
    input  logic                                  b_ovf,
    output logic signed [stva_pkg::IN_BITS-1:0]   res_sec,
    output logic signed [stva_pkg::USEC_BITS-1:0] res_usec,
    output logic [stva_pkg::SIGN_BITS-1:0]        sign_code,
    output logic                                  overflow
);

    localparam int UB = stva_pkg::USEC_BITS;
    localparam int SW = SEC_BITS + 2;
    localparam logic signed [UB-1:0] USEC_S = $signed({1'b0, stva_pkg::USEC_PER_SEC});
    localparam logic signed [UB:0]   USEC_W = $signed({2'b00, stva_pkg::USEC_PER_SEC});

    // stage 4: sum and carry, compare
    logic signed [SW-1:0] sum_s4;
    logic signed [UB:0]   sum_u4;
    logic signed [SW-1:0] s4;
    logic signed [UB-1:0] u4;
    stva_pkg::sign_t      cmp4;
    logic                 ovf4;

    logic signed [SW-1:0] s4_s_reg;
    logic signed [UB-1:0] s4_u_reg;
    logic                 s4_ovf_reg;
    stva_pkg::sign_t      s4_cmp_reg;
    logic                 s4_is_cmp_reg;
    logic                 s4_add_b_reg;

    assign sum_s4 = SW'(a_sec) + SW'(b_sec);
    assign sum_u4 = (UB+1)'(a_usec) + (UB+1)'(b_usec);

    always_comb
    begin
        if (!ctl.add_b)
        begin
            s4 = SW'(a_sec);
            u4 = a_usec;
        end
        else if (sum_u4 >= USEC_W)
        begin
            s4 = sum_s4 + SW'(1);
            u4 = UB'(sum_u4 - USEC_W);
        end
        else if (sum_u4 <= -USEC_W)
        begin
            s4 = sum_s4 - SW'(1);
            u4 = UB'(sum_u4 + USEC_W);
        end
        else
        begin
            s4 = sum_s4;
            u4 = UB'(sum_u4);
        end
    end

    always_comb
    begin
        if (a_sec > b_sec)
            cmp4 = stva_pkg::SIGN_POS;
        else if (a_sec < b_sec)
            cmp4 = stva_pkg::SIGN_NEG;
        else if (a_usec > b_usec)
            cmp4 = stva_pkg::SIGN_POS;
        else if (a_usec < b_usec)
            cmp4 = stva_pkg::SIGN_NEG;
        else
            cmp4 = stva_pkg::SIGN_ZERO;
    end

    assign ovf4 = a_ovf | (b_ovf & (ctl.add_b | ctl.is_cmp));

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s4_s_reg      <= s4;
            s4_u_reg      <= u4;
            s4_ovf_reg    <= ovf4;
            s4_cmp_reg    <= cmp4;
            s4_is_cmp_reg <= ctl.is_cmp;
            s4_add_b_reg  <= ctl.add_b;
        end
    end

    // stage 5: sign fix-up, wrap, sign code
    logic signed [SW-1:0]       sf5;
    logic signed [UB-1:0]       uf5;
    logic signed [SEC_BITS-1:0] w5;
    logic                       ovf5;
    stva_pkg::sign_t            sign5;

    logic signed [stva_pkg::IN_BITS-1:0] res_sec_reg;
    logic signed [UB-1:0]                res_usec_reg;
    stva_pkg::sign_t                     sign_reg;
    logic                                ovf_reg;

    // a passed through unchanged keeps its wrapped seconds as they are
    always_comb
    begin
        if (s4_add_b_reg && s4_s_reg > 0 && s4_u_reg < 0)
        begin
            sf5 = s4_s_reg - SW'(1);
            uf5 = s4_u_reg + USEC_S;
        end
        else if (s4_add_b_reg && s4_s_reg < 0 && s4_u_reg > 0)
        begin
            sf5 = s4_s_reg + SW'(1);
            uf5 = s4_u_reg - USEC_S;
        end
        else
        begin
            sf5 = s4_s_reg;
            uf5 = s4_u_reg;
        end
    end

    assign w5   = $signed(sf5[SEC_BITS-1:0]);
    assign ovf5 = s4_ovf_reg | (SW'(w5) != sf5);

    always_comb
    begin
        if (s4_is_cmp_reg)
            sign5 = s4_cmp_reg;
        else if (w5 > 0 || (w5 == 0 && uf5 > 0))
            sign5 = stva_pkg::SIGN_POS;
        else if (w5 == 0 && uf5 == 0)
            sign5 = stva_pkg::SIGN_ZERO;
        else
            sign5 = stva_pkg::SIGN_NEG;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            res_sec_reg  <= w5[stva_pkg::IN_BITS-1:0];
            res_usec_reg <= uf5;
            sign_reg     <= sign5;
            ovf_reg      <= ovf5;
        end
    end

    assign res_sec   = res_sec_reg;
    assign res_usec  = res_usec_reg;
    assign sign_code = sign_reg;
    assign overflow  = ovf_reg;

endmodule

/* rtl/core/signed_time_value_alu_top.sv */
// throughput: one request per cycle; six register stages (input, reciprocal multiply,
// remainder correction, operand fix-up, sum and carry, result) advance together
// and hold while the result register is stalled
// reset clears only the stage valid flags; payload registers are not reset
module signed_time_value_alu_top #(
    parameter int SEC_BITS = stva_pkg::SEC_BITS_DEF
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_stall,
    input  logic [stva_pkg::CMD_BITS-1:0]         cmd,
    input  logic signed [stva_pkg::IN_BITS-1:0]   a_sec,
    input  logic signed [stva_pkg::IN_BITS-1:0]   a_usec,
    input  logic signed [stva_pkg::IN_BITS-1:0]   b_sec,
    input  logic signed [stva_pkg::IN_BITS-1:0]   b_usec,
    input  logic [stva_pkg::IN_BITS-1:0]          extra_millis,
    output logic                                  out_valid,
    input  logic                                  out_stall,
    output logic signed [stva_pkg::IN_BITS-1:0]   res_sec,
    output logic signed [stva_pkg::USEC_BITS-1:0] res_usec,
    output logic [stva_pkg::SIGN_BITS-1:0]        sign_code,
    output logic                                  overflow
);

    localparam int OP    = stva_pkg::OP_BITS;
    localparam int UB    = stva_pkg::USEC_BITS;
    localparam int DEPTH = stva_pkg::PIPE_DEPTH;

    logic             en;
    logic             accept;
    logic [DEPTH-1:0] valid_reg;
    logic [DEPTH-1:0] valid_next;

    assign en        = !valid_reg[DEPTH-1] || !out_stall;
    assign in_stall  = !en;
    assign accept    = in_valid && en;
    assign out_valid = valid_reg[DEPTH-1];

    always_comb
    begin
        if (en)
            valid_next = {valid_reg[DEPTH-2:0], accept};
        else
            valid_next = valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else
            valid_reg <= valid_next;
    end

    // input register
    logic [stva_pkg::CMD_BITS-1:0]       cmd_reg;
    logic signed [stva_pkg::IN_BITS-1:0] a_sec_reg;
    logic signed [stva_pkg::IN_BITS-1:0] a_usec_reg;
    logic signed [stva_pkg::IN_BITS-1:0] b_sec_reg;
    logic signed [stva_pkg::IN_BITS-1:0] b_usec_reg;
    logic [stva_pkg::IN_BITS-1:0]        ms_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            cmd_reg    <= cmd;
            a_sec_reg  <= a_sec;
            a_usec_reg <= a_usec;
            b_sec_reg  <= b_sec;
            b_usec_reg <= b_usec;
            ms_reg     <= extra_millis;
        end
    end

    // command decode and second operand select
    stva_pkg::ctl_t       ctl0;
    logic                 b_ms0;
    logic signed [OP-1:0] b_sec0;
    logic signed [OP-1:0] b_usec0;

    always_comb
    begin
        ctl0    = '0;
        b_ms0   = 1'b0;
        b_sec0  = OP'(b_sec_reg);
        b_usec0 = OP'(b_usec_reg);
        case (cmd_reg)
            stva_pkg::CMD_ADD:
            begin
                ctl0.add_b = 1'b1;
            end
            stva_pkg::CMD_SUB:
            begin
                ctl0.add_b = 1'b1;
                b_sec0     = -OP'(b_sec_reg);
                b_usec0    = -OP'(b_usec_reg);
            end
            stva_pkg::CMD_ADD_MS:
            begin
                ctl0.add_b = 1'b1;
                b_ms0      = 1'b1;
                b_sec0     = '0;
                b_usec0    = $signed({1'b0, ms_reg});
            end
            stva_pkg::CMD_CMP:
            begin
                ctl0.is_cmp = 1'b1;
            end
            default:
            begin
                ctl0 = '0;
            end
        endcase
    end

    stva_pkg::ctl_t ctl1_reg;
    stva_pkg::ctl_t ctl2_reg;
    stva_pkg::ctl_t ctl3_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ctl1_reg <= ctl0;
            ctl2_reg <= ctl1_reg;
            ctl3_reg <= ctl2_reg;
        end
    end

    logic signed [SEC_BITS-1:0] na_sec;
    logic signed [UB-1:0]       na_usec;
    logic                       na_ovf;
    logic signed [SEC_BITS-1:0] nb_sec;
    logic signed [UB-1:0]       nb_usec;
    logic                       nb_ovf;

    stva_norm #(
        .SEC_BITS (SEC_BITS)
    ) u_norm_a (
        .clk     (clk),
        .en      (en),
        .ms_mode (1'b0),
        .op_sec  (OP'(a_sec_reg)),
        .op_usec (OP'(a_usec_reg)),
        .sec     (na_sec),
        .usec    (na_usec),
        .ovf     (na_ovf)
    );

    stva_norm #(
        .SEC_BITS (SEC_BITS)
    ) u_norm_b (
        .clk     (clk),
        .en      (en),
        .ms_mode (b_ms0),
        .op_sec  (b_sec0),
        .op_usec (b_usec0),
        .sec     (nb_sec),
        .usec    (nb_usec),
        .ovf     (nb_ovf)
    );

    stva_comb #(
        .SEC_BITS (SEC_BITS)
    ) u_comb (
        .clk       (clk),
        .en        (en),
        .ctl       (ctl3_reg),
        .a_sec     (na_sec),
        .a_usec    (na_usec),
        .a_ovf     (na_ovf),
        .b_sec     (nb_sec),
        .b_usec    (nb_usec),
        .b_ovf     (nb_ovf),
        .res_sec   (res_sec),
        .res_usec  (res_usec),
        .sign_code (sign_code),
        .overflow  (overflow)
    );

`include "signed_time_value_alu_top_macros.svh"

    `STVA_ASSERT_NOW(a_stall_only_when_full, in_stall, out_valid && out_stall, "input stalled without a blocked result")
    `STVA_ASSERT_NOW(a_usec_in_range, out_valid, ($signed(res_usec) < 21'sd1000000) && ($signed(res_usec) > -21'sd1000000), "result microseconds out of range")
    `STVA_ASSERT_NEXT(a_no_repeat, out_valid && !out_stall && !valid_reg[DEPTH-2], !out_valid, "result presented twice")

endmodule
